FILE: hw/rtl/fftss_pkg.sv
// Shared types, constants and twiddle math for the radix-2 FFT unit
`timescale 1ns / 1ps
package fftss_pkg;

  localparam int FQ_DEPTH = 4;
  localparam int OQ_DEPTH = 2;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Taylor term divisors: (2k-1)(2k) for cosine, (2k)(2k+1) for sine
  localparam longint unsigned TC_DIV [1:9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};
  localparam longint unsigned TS_DIV [1:9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

  typedef struct packed {
    logic               is_read;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } item_t;

  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [23:0]        mag;
    logic               last;
    logic               err;
  } result_t;

  function automatic logic [23:0] sat24(input logic signed [63:0] v);
    logic [23:0] r;
    if (v > 64'sd8388607) r = 24'h7FFFFF;
    else if (v < -64'sd8388608) r = 24'h800000;
    else r = v[23:0];
    return r;
  endfunction

  // Round a Q30 value to the twiddle scale 2^(tb-2), clamped to [0, 1]
  function automatic longint to_tw(input longint v, input int tb);
    longint x;
    longint unsigned u;
    x = v;
    if (x < 0) x = 0;
    if (x > longint'(Q30_ONE)) x = longint'(Q30_ONE);
    u = longint'(x) + (64'd1 << (31 - tb));
    return longint'(u >> (32 - tb));
  endfunction

  // Twiddle for a 32-bit phase; returns {wr, wi} as two 32-bit words
  function automatic logic [63:0] tw_calc(input logic [31:0] p, input int tb);
    longint unsigned r, x, x2, tc, ts;
    longint c, s, cv, sv, wr, wi;
    logic [1:0] q;
    q  = p[31:30];
    r  = {34'd0, p[29:0]};
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    tc = Q30_ONE;
    ts = x;
    c  = longint'(Q30_ONE);
    s  = longint'(x);
    for (int k = 1; k <= 9; k++) begin
      tc = ((tc * x2) >> 30) / TC_DIV[k];
      ts = ((ts * x2) >> 30) / TS_DIV[k];
      if (k % 2 == 1) begin
        c = c - longint'(tc);
        s = s - longint'(ts);
      end else begin
        c = c + longint'(tc);
        s = s + longint'(ts);
      end
    end
    cv = to_tw(c, tb);
    sv = to_tw(s, tb);
    unique case (q)
      2'd0: begin wr = cv;  wi = sv;  end
      2'd1: begin wr = -sv; wi = cv;  end
      2'd2: begin wr = -cv; wi = -sv; end
      default: begin wr = sv; wi = -cv; end
    endcase
    return {wr[31:0], wi[31:0]};
  endfunction

endpackage

FILE: hw/rtl/fftss_front.sv
// Input word queue and opcode decode
`timescale 1ns / 1ps
module fftss_front import fftss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_opcode,
  input  logic signed [15:0] in_sample_re,
  input  logic signed [15:0] in_sample_im,
  output item_t              item,
  output logic               item_valid,
  input  logic               item_pop
);

  localparam int PW = $clog2(FQ_DEPTH);

  item_t         q_r [FQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push_ok, pop_ok;

  assign in_full    = (cnt_r == (PW+1)'(FQ_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rp_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r].is_read <= in_opcode;
      q_r[wp_r].re      <= in_sample_re;
      q_r[wp_r].im      <= in_sample_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + PW'(1);
      if (pop_ok)  rp_r <= rp_r + PW'(1);
      if (push_ok && !pop_ok)      cnt_r <= cnt_r + (PW+1)'(1);
      else if (pop_ok && !push_ok) cnt_r <= cnt_r - (PW+1)'(1);
    end
  end

endmodule

FILE: hw/rtl/fftss_outq.sv
// Result word queue toward the output port
`timescale 1ns / 1ps
module fftss_outq import fftss_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  result_t res,
  input  logic    res_push,
  output logic    res_full,
  output result_t head,
  output logic    out_empty,
  input  logic    out_pop
);

  localparam int PW = $clog2(OQ_DEPTH);

  result_t       q_r [OQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push_ok, pop_ok;

  assign res_full  = (cnt_r == (PW+1)'(OQ_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign head      = q_r[rp_r];
  assign push_ok   = res_push && !res_full;
  assign pop_ok    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + PW'(1);
      if (pop_ok)  rp_r <= rp_r + PW'(1);
      if (push_ok && !pop_ok)      cnt_r <= cnt_r + (PW+1)'(1);
      else if (pop_ok && !push_ok) cnt_r <= cnt_r - (PW+1)'(1);
    end
  end

endmodule

FILE: hw/rtl/fftss_core.sv
// Frame store, transform sequencer, butterfly datapath and magnitude unit
`timescale 1ns / 1ps
module fftss_core import fftss_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] point_count,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_pop,
  output result_t     res,
  output logic        res_push,
  input  logic        res_full
);

  localparam int LM   = $clog2(MAX_POINTS);
  localparam int NW   = LM + 1;
  localparam int LGW  = $clog2(LM + 1);
  localparam int TIW  = (LM > 1) ? LM - 1 : 1;
  localparam int HALF = 2 ** (LM - 1);
  localparam int TB   = TWIDDLE_BITS;
  localparam int T    = TB - 2;
  localparam int PW   = TB + 25;
  localparam int CW   = (NW > 11) ? NW : 11;

  typedef logic [2*TB-1:0] twtab_t [HALF];

  function automatic twtab_t build_tab();
    twtab_t     tab;
    logic [63:0] w;
    for (int i = 0; i < HALF; i++) begin
      w = tw_calc(32'(i) << (32 - LM), TB);
      tab[i] = {w[32+TB-1:32], w[TB-1:0]};
    end
    return tab;
  endfunction

  localparam twtab_t TW_TAB = build_tab();

  function automatic logic [LM-1:0] rev_lm(input logic [LM-1:0] v);
    logic [LM-1:0] r;
    for (int i = 0; i < LM; i++) r[i] = v[LM-1-i];
    return r;
  endfunction

  function automatic logic [TIW-1:0] rev_tiw(input logic [TIW-1:0] v);
    logic [TIW-1:0] r;
    for (int i = 0; i < TIW; i++) r[i] = v[TIW-1-i];
    return r;
  endfunction

  typedef enum logic [3:0] {
    IDLE, SIZE, FILL, PERM, SW1, SW2, BF, BF_MUL, BF_ADD, HSWAP, RD_MUL, RD_SUM, SQRT
  } state_t;

  state_t                state_r, ret_r;
  logic [NW-1:0]         lc_r, rdc_r, n_r, cnt_r, j_r;
  logic                  fr_r, last_r;
  logic [LGW-1:0]        lg_r, s_r;
  logic [TIW-1:0]        t_r;
  logic [LM-1:0]         sa_r, sb_r, ja_r, ka_r;
  logic [47:0]           qa_r, q0_r, q1_r;
  logic [2*TB-1:0]       tw_r;
  logic signed [PW-1:0]  prr_r, pii_r, pri_r, pir_r;
  logic [23:0]           re_r, im_r;
  logic [47:0]           pre_r, pim_r, v_r, rt_r, bit_r;

  logic [47:0]           mem [2**LM];

  logic                  we;
  logic [LM-1:0]         wa, ra0, ra1;
  logic [47:0]           wd;
  logic [TIW-1:0]        tw_idx;

  // decoded values
  logic [NW-1:0]         lc_base, lc_new, halfn, idx, rvj;
  logic [CW-1:0]         pc_eff;
  logic                  do_load, do_read, ends_frame;
  logic [LM-1:0]         tl, smask, bj, bk;
  logic [TIW-1:0]        blk;
  logic signed [24:0]    sr, si, dr, di;
  logic signed [TB-1:0]  wr, wi;
  logic signed [PW:0]    xr, xi;
  logic [47:0]           rb;

  always_comb begin
    pc_eff = CW'(point_count);
    if (pc_eff == '0) pc_eff = CW'(1);
    if (pc_eff > CW'(MAX_POINTS)) pc_eff = CW'(MAX_POINTS);
  end

  assign item_pop   = (state_r == IDLE) && item_valid && (!item.is_read || !res_full);
  assign do_load    = item_pop && !item.is_read;
  assign do_read    = item_pop && item.is_read;
  assign lc_base    = fr_r ? '0 : lc_r;
  assign lc_new     = (lc_base < NW'(MAX_POINTS)) ? lc_base + NW'(1) : lc_base;
  assign ends_frame = (CW'(lc_new) >= pc_eff);
  assign halfn      = n_r >> 1;
  assign idx        = rdc_r & (n_r - NW'(1));
  assign rvj        = NW'(rev_lm(j_r[LM-1:0]) >> (LGW'(LM) - lg_r));

  // butterfly addressing: t-th butterfly of stage s
  assign tl    = LM'(t_r);
  assign smask = (LM'(1) << s_r) - LM'(1);
  assign bj    = ((tl >> s_r) << (s_r + LGW'(1))) | (tl & smask);
  assign bk    = bj | (LM'(1) << s_r);
  assign blk   = t_r >> s_r;
  assign tw_idx = rev_tiw(blk);

  assign wr = signed'(tw_r[2*TB-1:TB]);
  assign wi = signed'(tw_r[TB-1:0]);
  assign sr = {q0_r[47], q0_r[47:24]} + {q1_r[47], q1_r[47:24]} + 25'sd1;
  assign si = {q0_r[23], q0_r[23:0]}  + {q1_r[23], q1_r[23:0]}  + 25'sd1;
  assign dr = {q0_r[47], q0_r[47:24]} - {q1_r[47], q1_r[47:24]};
  assign di = {q0_r[23], q0_r[23:0]}  - {q1_r[23], q1_r[23:0]};
  assign xr = ((PW+1)'(prr_r) - (PW+1)'(pii_r) + ((PW+1)'(1) << T)) >>> (T + 1);
  assign xi = ((PW+1)'(pri_r) + (PW+1)'(pir_r) + ((PW+1)'(1) << T)) >>> (T + 1);
  assign rb = rt_r + bit_r;

  // memory ports
  always_comb begin
    we  = 1'b0;
    wa  = j_r[LM-1:0];
    wd  = '0;
    ra0 = j_r[LM-1:0];
    ra1 = rvj[LM-1:0];
    unique case (state_r)
      IDLE: begin
        ra0 = idx[LM-1:0];
        if (do_load && lc_base < NW'(MAX_POINTS)) begin
          we = 1'b1;
          wa = lc_base[LM-1:0];
          wd = {{8{item.re[15]}}, item.re, {8{item.im[15]}}, item.im};
        end
      end
      FILL:   we = (j_r < n_r);
      SW1: begin
        we = 1'b1;
        wa = sa_r;
        wd = q1_r;
      end
      SW2: begin
        we = 1'b1;
        wa = sb_r;
        wd = qa_r;
      end
      BF: begin
        ra0 = bj;
        ra1 = bk;
      end
      BF_MUL: begin
        we = 1'b1;
        wa = ja_r;
        wd = {sr[24:1], si[24:1]};
      end
      BF_ADD: begin
        we = 1'b1;
        wa = ka_r;
        wd = {sat24(64'(xr)), sat24(64'(xi))};
      end
      HSWAP: ra1 = j_r[LM-1:0] + halfn[LM-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    q0_r <= mem[ra0];
    q1_r <= mem[ra1];
    tw_r <= TW_TAB[tw_idx];
  end

  always_comb begin
    res_push = (do_read && !fr_r) || (state_r == SQRT && bit_r == '0);
    if (state_r == IDLE) begin
      res = '{re: '0, im: '0, mag: '0, last: 1'b0, err: 1'b1};
    end else begin
      res = '{re: re_r, im: im_r, mag: rt_r[23:0], last: last_r, err: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      ret_r   <= PERM;
      lc_r    <= '0;
      rdc_r   <= '0;
      fr_r    <= 1'b0;
      n_r     <= NW'(1);
      lg_r    <= '0;
    end else begin
      unique case (state_r)
        IDLE: begin
          if (do_load) begin
            lc_r <= lc_new;
            fr_r <= 1'b0;
            if (fr_r) rdc_r <= '0;
            if (ends_frame) begin
              cnt_r   <= lc_new;
              n_r     <= NW'(1);
              lg_r    <= '0;
              state_r <= SIZE;
            end
          end else if (do_read && fr_r) begin
            last_r  <= (idx == n_r - NW'(1));
            rdc_r   <= (idx + NW'(1)) & (n_r - NW'(1));
            state_r <= RD_MUL;
          end
        end
        SIZE: begin
          if (n_r < cnt_r) begin
            n_r  <= n_r << 1;
            lg_r <= lg_r + LGW'(1);
          end else begin
            j_r     <= cnt_r;
            state_r <= FILL;
          end
        end
        FILL: begin
          if (j_r < n_r) begin
            j_r <= j_r + NW'(1);
          end else begin
            j_r     <= '0;
            state_r <= PERM;
          end
        end
        PERM: begin
          if (j_r == n_r) begin
            j_r <= '0;
            t_r <= '0;
            s_r <= '0;
            state_r <= (lg_r == '0) ? HSWAP : BF;
          end else if (j_r < rvj) begin
            sa_r    <= j_r[LM-1:0];
            sb_r    <= rvj[LM-1:0];
            ret_r   <= PERM;
            state_r <= SW1;
          end else begin
            j_r <= j_r + NW'(1);
          end
        end
        SW1: begin
          qa_r    <= q0_r;
          state_r <= SW2;
        end
        SW2: begin
          j_r     <= j_r + NW'(1);
          state_r <= ret_r;
        end
        BF: begin
          ja_r    <= bj;
          ka_r    <= bk;
          state_r <= BF_MUL;
        end
        BF_MUL: begin
          prr_r   <= PW'(wr * dr);
          pii_r   <= PW'(wi * di);
          pri_r   <= PW'(wr * di);
          pir_r   <= PW'(wi * dr);
          state_r <= BF_ADD;
        end
        BF_ADD: begin
          state_r <= BF;
          if (NW'(t_r) == halfn - NW'(1)) begin
            t_r <= '0;
            if (s_r == lg_r - LGW'(1)) begin
              j_r     <= '0;
              state_r <= HSWAP;
            end else begin
              s_r <= s_r + LGW'(1);
            end
          end else begin
            t_r <= t_r + TIW'(1);
          end
        end
        HSWAP: begin
          if (j_r < halfn) begin
            sa_r    <= j_r[LM-1:0];
            sb_r    <= j_r[LM-1:0] + halfn[LM-1:0];
            ret_r   <= HSWAP;
            state_r <= SW1;
          end else begin
            fr_r    <= 1'b1;
            rdc_r   <= '0;
            state_r <= IDLE;
          end
        end
        RD_MUL: begin
          re_r    <= q0_r[47:24];
          im_r    <= q0_r[23:0];
          pre_r   <= 48'(signed'(q0_r[47:24]) * signed'(q0_r[47:24]));
          pim_r   <= 48'(signed'(q0_r[23:0]) * signed'(q0_r[23:0]));
          state_r <= RD_SUM;
        end
        RD_SUM: begin
          v_r     <= pre_r + pim_r;
          rt_r    <= '0;
          bit_r   <= 48'd1 << 46;
          state_r <= SQRT;
        end
        SQRT: begin
          // one result bit per cycle
          if (bit_r != '0) begin
            if (v_r >= rb) begin
              v_r  <= v_r - rb;
              rt_r <= (rt_r >> 1) + bit_r;
            end else begin
              rt_r <= rt_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else begin
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_sqrt_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQRT) |-> fr_r)
    else $error("bin read without a finished frame");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r <= NW'(MAX_POINTS))
    else $error("load count beyond frame store");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fr_r |-> (rdc_r < n_r))
    else $error("read pointer outside frame");

endmodule

FILE: hw/rtl/fft_radix2_shift_scale_unit.sv
// Top level: radix-2 FFT with half swap and 1/n scaling, queue interfaces
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+--------------------------
//  input   | in_opcode, in_sample_re/im          | in_push & !in_full
//  result  | out_bin_re/im/mag, last, read_error | out_pop & !out_empty
//  config  | cfg_point_count                     | cfg_valid & cfg_ready
//
// A load word is taken from the input queue while the core is idle. The load that
// completes a frame then runs the transform on one shared butterfly: zero fill to n,
// bit-reversal swaps, log2 n butterfly stages and the half swap. A read squares and
// sums the bin, then runs a 24-step square root. Synchronous reset clears
// control state only; the frame store is not cleared. Input queue holds 4 words and
// the result queue 2, so each side stalls on its own.
`timescale 1ns / 1ps
module fft_radix2_shift_scale_unit import fftss_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_opcode,
  input  logic signed [15:0] in_sample_re,
  input  logic signed [15:0] in_sample_im,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [23:0] out_bin_re,
  output logic signed [23:0] out_bin_im,
  output logic [23:0]        out_bin_mag,
  output logic               out_last_bin,
  output logic               out_read_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_point_count
);

  logic [10:0] pc_r;
  item_t       item;
  logic        item_valid, item_pop;
  result_t     res, head;
  logic        res_push, res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      pc_r <= cfg_point_count;
    end
  end

  fftss_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_opcode    (in_opcode),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .item         (item),
    .item_valid   (item_valid),
    .item_pop     (item_pop)
  );

  fftss_core #(
    .MAX_POINTS   (MAX_POINTS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_count (pc_r),
    .item        (item),
    .item_valid  (item_valid),
    .item_pop    (item_pop),
    .res         (res),
    .res_push    (res_push),
    .res_full    (res_full)
  );

  fftss_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full),
    .head      (head),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  assign out_bin_re     = head.re;
  assign out_bin_im     = head.im;
  assign out_bin_mag    = head.mag;
  assign out_last_bin   = head.last;
  assign out_read_error = head.err;

endmodule

FILE: dv/fft_radix2_shift_scale_checker.sv
// Bin predictor and scoreboard for the radix-2 FFT unit
`timescale 1ns / 1ps
module fft_radix2_shift_scale_checker import fftss_pkg::*; #(
  parameter bit OP_READ = 1'b1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic               in_opcode,
  input  logic signed [15:0] in_sample_re,
  input  logic signed [15:0] in_sample_im,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [23:0] out_bin_re,
  input  logic signed [23:0] out_bin_im,
  input  logic [23:0]        out_bin_mag,
  input  logic               out_last_bin,
  input  logic               out_read_error,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [10:0]        cfg_point_count,
  output int                 fail_count,
  output int                 outstanding
);

  localparam int MAXPTS = 1024;
  localparam int TSH    = 14;  // twiddle scale exponent

  longint      frame_re [0:2*MAXPTS-1];
  longint      frame_im [0:2*MAXPTS-1];
  int unsigned loaded, bin_ptr, frame_lg, pts_reg;
  bit          done;
  result_t     bins_due [$];

  assign outstanding = bins_due.size();

  function automatic int unsigned bit_rev(input int unsigned v, input int unsigned bits);
    int unsigned r;
    r = 0;
    for (int i = 0; i < bits; i++) begin
      r = (r << 1) | (v & 1);
      v = v >> 1;
    end
    return r;
  endfunction

  function automatic longint clip24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint tw_round(input longint v);
    if (v < 0) v = 0;
    if (v > 64'sd1073741824) v = 64'sd1073741824;
    return (v + (64'sd1 << (29 - TSH))) >>> (30 - TSH);
  endfunction

  function automatic void twiddle(input int unsigned e, input int unsigned lg,
                                  output longint wr, output longint wi);
    longint unsigned ph, r, x, x2, tc, ts;
    longint c, s, cv, sv;
    logic [1:0] quad;
    ph   = (longint'(e) << (32 - lg)) & 64'hFFFF_FFFF;
    quad = ph[31:30];
    r    = ph & 64'h3FFF_FFFF;
    x    = (r * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    tc   = 64'd1073741824;
    ts   = x;
    c    = 64'sd1073741824;
    s    = longint'(x);
    for (int k = 1; k <= 9; k++) begin
      tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        c -= longint'(tc);
        s -= longint'(ts);
      end else begin
        c += longint'(tc);
        s += longint'(ts);
      end
    end
    cv = tw_round(c);
    sv = tw_round(s);
    case (quad)
      2'd0: begin wr = cv;  wi = sv;  end
      2'd1: begin wr = -sv; wi = cv;  end
      2'd2: begin wr = -cv; wi = -sv; end
      default: begin wr = sv; wi = -cv; end
    endcase
  endfunction

  task automatic run_fft(input int unsigned cnt);
    int unsigned n, lg, r, blk, k;
    longint wr, wi, ar, ai, br, bi, dr, di, tmp;
    n  = 1;
    lg = 0;
    while (n < cnt) begin
      n <<= 1;
      lg++;
    end
    for (int j = cnt; j < n; j++) begin
      frame_re[j] = 0;
      frame_im[j] = 0;
    end
    for (int j = 0; j < n; j++) begin
      r = bit_rev(j, lg);
      if (j < r) begin
        tmp = frame_re[j]; frame_re[j] = frame_re[r]; frame_re[r] = tmp;
        tmp = frame_im[j]; frame_im[j] = frame_im[r]; frame_im[r] = tmp;
      end
    end
    for (int mh = 1; mh < n; mh <<= 1) begin
      blk = 0;
      for (int i = 0; i < n; i += 2 * mh) begin
        twiddle(bit_rev(blk, lg - 1), lg, wr, wi);
        for (int j = i; j < i + mh; j++) begin
          k  = j + mh;
          ar = frame_re[j]; ai = frame_im[j];
          br = frame_re[k]; bi = frame_im[k];
          dr = ar - br;
          di = ai - bi;
          frame_re[j] = clip24((ar + br + 1) >>> 1);
          frame_im[j] = clip24((ai + bi + 1) >>> 1);
          frame_re[k] = clip24((wr * dr - wi * di + (64'sd1 << TSH)) >>> (TSH + 1));
          frame_im[k] = clip24((wr * di + wi * dr + (64'sd1 << TSH)) >>> (TSH + 1));
        end
        blk++;
      end
    end
    // swap the lower and upper halves of the frame
    for (int j = 0; j < n / 2; j++) begin
      tmp = frame_re[j]; frame_re[j] = frame_re[n/2 + j]; frame_re[n/2 + j] = tmp;
      tmp = frame_im[j]; frame_im[j] = frame_im[n/2 + j]; frame_im[n/2 + j] = tmp;
    end
    frame_lg = lg;
  endtask

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bv;
    res = 0;
    bv  = 64'h4000_0000_0000_0000;
    while (bv > v) bv >>= 2;
    while (bv != 0) begin
      if (v >= res + bv) begin
        v  -= res + bv;
        res = (res >> 1) + bv;
      end else begin
        res >>= 1;
      end
      bv >>= 2;
    end
    return res;
  endfunction

  task automatic take_word(input logic op, input logic signed [15:0] sre,
                           input logic signed [15:0] sim);
    int unsigned pc, n, idx;
    longint re, im;
    result_t b;
    b = '0;
    if (op != OP_READ) begin
      pc = (pts_reg < 1) ? 1 : (pts_reg > MAXPTS) ? MAXPTS : pts_reg;
      if (done) begin
        done    = 0;
        loaded  = 0;
        bin_ptr = 0;
      end
      if (loaded < MAXPTS) begin
        frame_re[loaded] = sre;
        frame_im[loaded] = sim;
        loaded++;
      end
      if (loaded >= pc) begin
        run_fft(loaded);
        done    = 1;
        bin_ptr = 0;
      end
    end else if (!done) begin
      b.err = 1'b1;
      bins_due.push_back(b);
    end else begin
      n      = 1 << frame_lg;
      idx    = bin_ptr & (n - 1);
      re     = frame_re[idx];
      im     = frame_im[idx];
      b.re   = re[23:0];
      b.im   = im[23:0];
      b.mag  = floor_sqrt(longint'(re * re + im * im));
      b.last = (idx == n - 1);
      bin_ptr = (idx + 1) & (n - 1);
      bins_due.push_back(b);
    end
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t b;
    if (!rst_n) begin
      loaded     = 0;
      bin_ptr    = 0;
      frame_lg   = 0;
      done       = 0;
      pts_reg    = MAXPTS;
      fail_count = 0;
      bins_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) pts_reg = cfg_point_count;
      if (out_pop && !out_empty) begin
        if (bins_due.size() == 0) begin
          $display("%0t: unexpected word expected none actual re %h im %h",
                   $time, out_bin_re, out_bin_im);
          fail_count++;
        end else begin
          b = bins_due.pop_front();
          check_field("bin_re", b.re, out_bin_re);
          check_field("bin_im", b.im, out_bin_im);
          check_field("bin_mag", b.mag, out_bin_mag);
          check_field("last_bin", b.last, out_last_bin);
          check_field("read_error", b.err, out_read_error);
        end
      end
      if (in_push && !in_full) take_word(in_opcode, in_sample_re, in_sample_im);
    end
  end

endmodule

FILE: dv/tb_fft_radix2_shift_scale_unit.sv
// Testbench top: stimulus, stall patterns and verdict for the radix-2 FFT unit
`timescale 1ns / 1ps
module tb_fft_radix2_shift_scale_unit;

  localparam bit OP_LOAD = 1'b0;
  localparam bit OP_READ = 1'b1;
  localparam int RAND_WORDS = 1150;
  // words spent on the closing full-size frame: 1024 loads and 40 reads
  localparam int FULL_WORDS = 1064;

  logic               clk, rst_n;
  logic               in_push, in_full, in_opcode;
  logic signed [15:0] in_sample_re, in_sample_im;
  logic               out_empty, out_pop;
  logic signed [23:0] out_bin_re, out_bin_im;
  logic [23:0]        out_bin_mag;
  logic               out_last_bin, out_read_error;
  logic               cfg_valid, cfg_ready;
  logic [10:0]        cfg_point_count;
  int                 fail_count, outstanding;

  int loads_sent, reads_sent, cfg_writes, burst_left, pop_pct;
  bit steady;

  fft_radix2_shift_scale_unit dut (.*);

  fft_radix2_shift_scale_checker #(.OP_READ(OP_READ)) scoreboard (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // receiver: pop rate is redrawn at regular intervals, from always to rare
  always @(posedge clk) begin
    int cyc;
    cyc++;
    if (cyc % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: pop_pct <= 100;
        1: pop_pct <= 70;
        2: pop_pct <= 30;
        default: pop_pct <= 5;
      endcase
    end
    out_pop <= ($urandom_range(0, 99) < pop_pct);
  end

  task automatic send_word(input bit op, input logic [15:0] re, input logic [15:0] im);
    int gap;
    in_push      <= 1'b1;
    in_opcode    <= op;
    in_sample_re <= re;
    in_sample_im <= im;
    do @(posedge clk); while (in_full);
    if (op == OP_READ) reads_sent++;
    else loads_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 8);
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_rand();
    send_word(OP_LOAD, rand_sample(), rand_sample());
  endtask

  // stop sending, drain every expected word, then let a transform finish
  task automatic settle(input int pts);
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200 + 30 * pts) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    cfg_valid       <= 1'b1;
    cfg_point_count <= 11'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic int frame_size(input int pc);
    int n;
    n = 1;
    while (n < pc) n <<= 1;
    return n;
  endfunction

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int pc, eff, n, nreads;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_opcode       = OP_LOAD;
    in_sample_re    = '0;
    in_sample_im    = '0;
    cfg_valid       = 1'b0;
    cfg_point_count = '0;
    out_pop         = 1'b0;
    pop_pct         = 100;
    steady          = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: read with no frame, single-point frames with wrap, extremes
    send_word(OP_READ, 16'h7FFF, 16'h8000);
    settle(4);
    write_count(1);
    send_word(OP_LOAD, 16'h7FFF, 16'h8000);
    send_word(OP_READ, 0, 0);
    send_word(OP_READ, 0, 0);
    settle(4);
    write_count(2);
    send_word(OP_LOAD, 16'h8000, 16'h8000);
    send_word(OP_LOAD, 16'h7FFF, 16'h7FFF);
    send_word(OP_READ, 0, 0);
    send_word(OP_READ, 0, 0);
    send_word(OP_LOAD, 16'h7FFF, 16'h8000);  // load on finished frame
    send_word(OP_READ, 0, 0);                // frame still open
    send_word(OP_LOAD, 16'h8000, 16'h7FFF);
    repeat (3) send_word(OP_READ, 0, 0);
    settle(4);
    write_count(2047);                       // clamps to the largest frame
    repeat (5) load_rand();
    settle(16);
    write_count(4);                          // lowered mid frame: next load ends it
    load_rand();
    repeat (4) send_word(OP_READ, 0, 0);
    settle(16);
    write_count(0);                          // acts as one point
    send_word(OP_LOAD, 16'h0001, 16'hFFFF);
    send_word(OP_READ, 0, 0);
    settle(4);

    // random: frames of small sizes, noise reads, partial and wrapped readouts
    while (loads_sent + reads_sent < RAND_WORDS - FULL_WORDS) begin
      case ($urandom_range(0, 9))
        0: pc = 0;
        1: pc = 1;
        2: pc = 2;
        3: pc = $urandom_range(3, 5);
        4: pc = 8;
        5: pc = $urandom_range(9, 17);
        6: pc = 32;
        default: pc = $urandom_range(1, 40);
      endcase
      eff    = (pc == 0) ? 1 : pc;
      n      = frame_size(eff);
      steady = ($urandom_range(0, 3) == 0);
      write_count(pc);
      repeat ($urandom_range(1, 3)) begin
        for (int i = 0; i < eff; i++) begin
          if ($urandom_range(0, 19) == 0) send_word(OP_READ, rand_sample(), rand_sample());
          load_rand();
        end
        case ($urandom_range(0, 3))
          0: nreads = $urandom_range(0, n);
          1: nreads = n + $urandom_range(1, n);
          default: nreads = n;
        endcase
        repeat (nreads) send_word(OP_READ, rand_sample(), rand_sample());
      end
      settle(n);
    end

    // one full-size frame
    steady = 1'b0;
    write_count(1024);
    repeat (1024) load_rand();
    repeat (FULL_WORDS - 1024) send_word(OP_READ, 0, 0);
    settle(1024);

    $display("Run covered %0d loads and %0d reads over %0d point-count writes,",
             loads_sent, reads_sent, cfg_writes);
    $display("frames from one point up to 1024, with error reads and wrapped readouts.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
